// ----- rtl/mshp_pkg.sv -----
// ----------------------------------------------------------------------------
// mshp_pkg
// Shared types and constants for the MPEG-1/2 sequence header parser.
// ----------------------------------------------------------------------------
package mshp_pkg;

  // Start codes compared against the 4-byte window
  localparam logic [31:0] CODE_SEQUENCE  = 32'h0000_01b3;
  localparam logic [31:0] CODE_EXTENSION = 32'h0000_01b5;
  localparam logic [31:0] CODE_PICTURE   = 32'h0000_0100;

  // Extension identifier for a sequence extension
  localparam logic [3:0] EXT_ID_SEQUENCE = 4'h1;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int SIZE_W    = 14;
  localparam int CODE_W    = 4;
  localparam int BRATE_W   = 30;
  localparam int BPS_W     = 39;
  localparam int PROFILE_W = 8;
  localparam int IDX_W     = 4;

  // Byte counts within capture phases
  localparam logic [IDX_W-1:0] SCAN_LAST_IDX = 4'd3;
  localparam logic [IDX_W-1:0] HDR_LAST_IDX  = 4'd7;
  localparam logic [IDX_W-1:0] EXT_LAST_IDX  = 4'd3;
  localparam logic [IDX_W-1:0] EXT_RESUME_IDX = 4'd2;

  typedef enum logic [1:0] {
    PH_SCAN   = 2'd0,
    PH_HEADER = 2'd1,
    PH_EXT    = 2'd2
  } phase_t;

  // Complete parse state
  typedef struct packed {
    logic [23:0]           win;
    phase_t                phase;
    logic [IDX_W-1:0]      idx;
    logic                  seen;
    logic                  fin;
    logic                  mp2;
    logic [SIZE_W-1:0]     wid;
    logic [SIZE_W-1:0]     hgt;
    logic [CODE_W-1:0]     asp;
    logic [CODE_W-1:0]     rate;
    logic [BRATE_W-1:0]    brate;
    logic [PROFILE_W-1:0]  prof;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    win: '0, phase: PH_SCAN, idx: '0, seen: 1'b0, fin: 1'b0, mp2: 1'b0,
    wid: '0, hgt: '0, asp: '0, rate: '0, brate: '0, prof: '0
  };

endpackage

// ----- rtl/mshp_if.sv -----
// ----------------------------------------------------------------------------
// mshp_in_if / mshp_out_if
// Valid/ready channels for stream bytes in and parse results out.
// ----------------------------------------------------------------------------
interface mshp_in_if;
  logic                         valid;
  logic                         ready;
  logic [mshp_pkg::BYTE_W-1:0]  data_byte;
  logic                         first_of_buffer;
  logic                         last_of_buffer;

  modport source (output valid, data_byte, first_of_buffer, last_of_buffer,
                  input ready);
  modport sink   (input valid, data_byte, first_of_buffer, last_of_buffer,
                  output ready);
endinterface

interface mshp_out_if;
  logic                            valid;
  logic                            ready;
  logic                            header_found;
  logic                            ended_at_picture;
  logic                            is_mpeg2;
  logic [mshp_pkg::SIZE_W-1:0]     frame_width;
  logic [mshp_pkg::SIZE_W-1:0]     frame_height;
  logic [mshp_pkg::CODE_W-1:0]     aspect_ratio_info;
  logic [mshp_pkg::CODE_W-1:0]     frame_rate_code;
  logic [mshp_pkg::BPS_W-1:0]      bitrate_bps;
  logic [mshp_pkg::PROFILE_W-1:0]  profile_level;

  modport source (output valid, header_found, ended_at_picture, is_mpeg2,
                  frame_width, frame_height, aspect_ratio_info, frame_rate_code,
                  bitrate_bps, profile_level, input ready);
  modport sink   (input valid, header_found, ended_at_picture, is_mpeg2,
                  frame_width, frame_height, aspect_ratio_info, frame_rate_code,
                  bitrate_bps, profile_level, output ready);
endinterface

// ----- rtl/mpeg2_sequence_header_parser_unit.sv -----
// ----------------------------------------------------------------------------
// mpeg2_sequence_header_parser_unit: MPEG-1/2 sequence header parser
// A result is valid in the cycle after the byte that causes it is accepted.
// One byte per cycle unless an unread result stalls input; one state register.
// Reset (rst_n low, synchronous) clears parse state and the result valid flag.
// ----------------------------------------------------------------------------
module mpeg2_sequence_header_parser_unit (
  input  logic         clk,
  input  logic         rst_n,
  mshp_in_if.sink      in_ch,
  mshp_out_if.source   out_ch
);
  import mshp_pkg::*;

  parse_state_t st_r, st_nxt;
  parse_state_t eff;
  logic         in_fire;
  logic         emit;
  logic         pic;
  logic [31:0]  code;
  logic [BPS_W-1:0] bps;

  // Result register
  logic                  out_valid_r;
  logic                  out_seen_r, out_pic_r, out_mp2_r;
  logic [SIZE_W-1:0]     out_wid_r, out_hgt_r;
  logic [CODE_W-1:0]     out_asp_r, out_rate_r;
  logic [BPS_W-1:0]      out_bps_r;
  logic [PROFILE_W-1:0]  out_prof_r;

  // Accept while the result slot is empty or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Per-byte parse update
  always_comb begin
    st_nxt = st_r;
    eff    = in_ch.first_of_buffer ? STATE_CLEAR : st_r;
    pic    = 1'b0;
    emit   = 1'b0;
    code   = {eff.win, in_ch.data_byte};
    if (in_fire) begin
      st_nxt = eff;
      if (!eff.fin) begin
        case (eff.phase)
          PH_SCAN: begin
            if (eff.idx == SCAN_LAST_IDX) begin
              if (code == CODE_SEQUENCE) begin
                st_nxt.seen  = 1'b1;
                st_nxt.wid   = '0;
                st_nxt.hgt   = '0;
                st_nxt.asp   = '0;
                st_nxt.rate  = '0;
                st_nxt.brate = '0;
                st_nxt.phase = PH_HEADER;
                st_nxt.idx   = '0;
              end else if (eff.seen && code == CODE_EXTENSION) begin
                st_nxt.phase = PH_EXT;
                st_nxt.idx   = '0;
              end else if (eff.seen && code == CODE_PICTURE) begin
                pic = 1'b1;
              end
            end else if (eff.idx < SCAN_LAST_IDX) begin
              st_nxt.idx = eff.idx + 1'b1;
            end else begin
              st_nxt.idx = '0;
            end
          end
          PH_HEADER: begin
            if (eff.idx <= HDR_LAST_IDX) begin
              case (eff.idx[2:0])
                3'd0: st_nxt.wid = {2'b00, in_ch.data_byte, 4'h0};
                3'd1: begin
                  st_nxt.wid = eff.wid | {10'b0, in_ch.data_byte[7:4]};
                  st_nxt.hgt = {2'b00, in_ch.data_byte[3:0], 8'h00};
                end
                3'd2: st_nxt.hgt = eff.hgt | {6'b0, in_ch.data_byte};
                3'd3: begin
                  st_nxt.asp  = in_ch.data_byte[7:4];
                  st_nxt.rate = in_ch.data_byte[3:0];
                end
                3'd4: st_nxt.brate = {12'b0, in_ch.data_byte, 10'b0};
                3'd5: st_nxt.brate = eff.brate | {20'b0, in_ch.data_byte, 2'b0};
                3'd6: st_nxt.brate = eff.brate | {28'b0, in_ch.data_byte[7:6]};
                default: ;
              endcase
              if (eff.idx == HDR_LAST_IDX) begin
                st_nxt.phase = PH_SCAN;
                st_nxt.idx   = '0;
              end else begin
                st_nxt.idx = eff.idx + 1'b1;
              end
            end else begin
              st_nxt.phase = PH_SCAN;
              st_nxt.idx   = '0;
            end
          end
          PH_EXT: begin
            if (eff.idx == EXT_LAST_IDX) begin
              // window holds ext bytes 0..2, current byte is ext byte 3
              if (eff.win[23:20] == EXT_ID_SEQUENCE) begin
                st_nxt.mp2   = 1'b1;
                st_nxt.prof  = {eff.win[19:16], eff.win[15:12]};
                st_nxt.wid   = {eff.win[8], eff.win[7], eff.wid[11:0]};
                st_nxt.hgt   = {eff.win[6:5], eff.hgt[11:0]};
                st_nxt.brate = {eff.win[4:0], in_ch.data_byte[7:1], eff.brate[17:0]};
              end
              st_nxt.phase = PH_SCAN;
              st_nxt.idx   = EXT_RESUME_IDX;
            end else if (eff.idx < EXT_LAST_IDX) begin
              st_nxt.idx = eff.idx + 1'b1;
            end else begin
              st_nxt.phase = PH_SCAN;
              st_nxt.idx   = '0;
            end
          end
          default: begin
            st_nxt.phase = PH_SCAN;
            st_nxt.idx   = '0;
          end
        endcase
        st_nxt.win = {eff.win[15:0], in_ch.data_byte};
        emit       = pic || in_ch.last_of_buffer;
        st_nxt.fin = emit;
      end
    end
  end

  // Bit rate times 400 = x*256 + x*128 + x*16
  assign bps = {1'b0, st_nxt.brate, 8'h00}
             + {2'b00, st_nxt.brate, 7'h00}
             + {5'b0, st_nxt.brate, 4'h0};

  // Parse state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= emit;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_seen_r <= st_nxt.seen;
      out_pic_r  <= pic;
      out_mp2_r  <= st_nxt.mp2;
      out_wid_r  <= st_nxt.wid;
      out_hgt_r  <= st_nxt.hgt;
      out_asp_r  <= st_nxt.asp;
      out_rate_r <= st_nxt.rate;
      out_bps_r  <= bps;
      out_prof_r <= st_nxt.prof;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.header_found      = out_seen_r;
  assign out_ch.ended_at_picture  = out_pic_r;
  assign out_ch.is_mpeg2          = out_mp2_r;
  assign out_ch.frame_width       = out_wid_r;
  assign out_ch.frame_height      = out_hgt_r;
  assign out_ch.aspect_ratio_info = out_asp_r;
  assign out_ch.frame_rate_code   = out_rate_r;
  assign out_ch.bitrate_bps       = out_bps_r;
  assign out_ch.profile_level     = out_prof_r;

`ifndef SYNTH
  // once a result is issued the buffer is closed
  a_fin_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> st_r.fin)
    else $error("finished flag not set after result");

  // a closed buffer gives nothing more until a new buffer starts
  a_no_emit_when_fin: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && st_r.fin && !in_ch.first_of_buffer |-> !emit)
    else $error("result issued after buffer finished");

  // picture end is only reachable after a sequence header
  a_pic_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pic_r |-> out_seen_r)
    else $error("picture end without sequence header");

  // extension capture only after a header
  a_ext_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_EXT |-> st_r.seen)
    else $error("extension phase without sequence header");
`endif

endmodule
